// ----- rtl/mma_pkg.sv -----
// package for the montgomery modular alu: request codes, field widths,
// datapath command and status structs; no dependencies
`timescale 1ns / 1ps

package mma_pkg;

  localparam int R_BITS = 32;
  localparam int VAL_W  = 31;
  localparam int EXP_W  = 63;
  localparam int REQ_W  = 3;
  localparam int IDX_W  = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SUB  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_MUL  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TO   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FROM = 3'd4;
  localparam logic [REQ_W-1:0] REQ_POW  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_INV  = 3'd6;
  localparam logic [REQ_W-1:0] REQ_BAD  = 3'd7;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MOD  = 2'd0;
  localparam logic [IDX_W-1:0] REG_MINV = 2'd1;
  localparam logic [IDX_W-1:0] REG_R2   = 2'd2;

  // operand pairs for a montgomery product
  localparam logic [2:0] SRC_AB     = 3'd0;
  localparam logic [2:0] SRC_AR2    = 3'd1;
  localparam logic [2:0] SRC_A1     = 3'd2;
  localparam logic [2:0] SRC_R21    = 3'd3;
  localparam logic [2:0] SRC_ACCB   = 3'd4;
  localparam logic [2:0] SRC_BB     = 3'd5;

  // destinations of a montgomery product
  localparam logic [1:0] DST_RES  = 2'd0;
  localparam logic [1:0] DST_ACC  = 2'd1;
  localparam logic [1:0] DST_BASE = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mont_en;
    logic [1:0] phase;
    logic [2:0] src;
    logic [1:0] dst;
    logic       e_shift;
    logic       fin_bad;
    logic       fin_addsub;
    logic       fin_acc;
  } cmd_t;

  typedef struct packed {
    logic             bad;
    logic [REQ_W-1:0] kind;
    logic             e_zero;
    logic             e_lsb;
    logic             e_hi_zero;
  } stat_t;

endpackage

// ----- rtl/montgomery_modular_alu.sv -----
// top level of the montgomery modular alu (R = 2^32, modulus below 2^31)
// instantiates mma_control and mma_datapath; uses mma_pkg
`timescale 1ns / 1ps

//  channel   handshake          payload
//  request   start, busy        req_type, operand_a, operand_b, exponent
//  result    done (one cycle)   result, error
//  config    wr_en              wr_index, wr_data
//
// a montgomery product runs through states S_M0, S_M1, S_M2 and S_M3 on the one shared 32x32 multiplier
// add, sub and error words go from idle through dispatch to done; mul, to and from run one product first
// power and inverse: one product to form montgomery one, then square-and-multiply from the exponent lsb up
// (a zero exponent ends after that first product); the exponent may be up to 63 bits wide
// rst is synchronous and clears the configuration registers, the error flag and the controller
// done is a one-cycle strobe; the receiver cannot stall, busy blocks new words

module montgomery_modular_alu (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [mma_pkg::REQ_W-1:0]   req_type,
  input  logic [mma_pkg::VAL_W-1:0]   operand_a,
  input  logic [mma_pkg::VAL_W-1:0]   operand_b,
  input  logic [mma_pkg::EXP_W-1:0]   exponent,
  output logic                        done,
  output logic [mma_pkg::VAL_W-1:0]   result,
  output logic                        error,
  input  logic                        wr_en,
  input  logic [mma_pkg::IDX_W-1:0]   wr_index,
  input  logic [mma_pkg::R_BITS-1:0]  wr_data
);
  import mma_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  mma_control u_control (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  // arithmetic
  mma_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .req_type  (req_type),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .exponent  (exponent),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .error     (error)
  );

endmodule

// ----- rtl/mma_datapath.sv -----
// datapath of the montgomery modular alu: configuration registers, operand
// registers, shared 32x32 multiplier and reduction; uses mma_pkg
`timescale 1ns / 1ps

module mma_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [mma_pkg::IDX_W-1:0]   wr_index,
  input  logic [mma_pkg::R_BITS-1:0]  wr_data,
  input  logic [mma_pkg::REQ_W-1:0]   req_type,
  input  logic [mma_pkg::VAL_W-1:0]   operand_a,
  input  logic [mma_pkg::VAL_W-1:0]   operand_b,
  input  logic [mma_pkg::EXP_W-1:0]   exponent,
  input  mma_pkg::cmd_t               cmd,
  output mma_pkg::stat_t              stat,
  output logic [mma_pkg::VAL_W-1:0]   result,
  output logic                        error
);
  import mma_pkg::*;

  logic [VAL_W-1:0]    modulus;
  logic [R_BITS-1:0]   modulus_inverse;
  logic [VAL_W-1:0]    r_squared;

  logic [REQ_W-1:0]    kind;
  logic                bad;
  logic [VAL_W-1:0]    opa, opb, acc, base;
  logic [EXP_W-1:0]    e;
  logic [2*R_BITS-1:0] mprod;
  logic [29:0]         xhi;

  logic                bad_in;
  logic [R_BITS-1:0]   mul_a, mul_b;
  logic [2*R_BITS-1:0] mul_p;
  logic [R_BITS-1:0]   t_raw, t_red;
  logic [VAL_W:0]      sum_ab, dif_ab;
  logic [VAL_W-1:0]    addsub;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus         <= '0;
      modulus_inverse <= '0;
      r_squared       <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MOD:  modulus         <= wr_data[VAL_W-1:0];
        REG_MINV: modulus_inverse <= wr_data;
        REG_R2:   r_squared       <= wr_data[VAL_W-1:0];
        default:  ;
      endcase
    end
  end

  // request validity
  always_comb begin
    bad_in = !modulus[0] || (modulus < VAL_W'(3)) || (req_type == REQ_BAD)
             || (operand_a >= modulus);
    if ((req_type == REQ_ADD || req_type == REQ_SUB || req_type == REQ_MUL)
        && (operand_b >= modulus))
      bad_in = 1'b1;
    if ((req_type == REQ_TO || req_type == REQ_POW || req_type == REQ_INV)
        && (r_squared >= modulus))
      bad_in = 1'b1;
  end

  // multiplier operand select per phase
  always_comb begin
    mul_a = mprod[R_BITS-1:0];
    mul_b = modulus_inverse;
    if (cmd.phase == 2'd0) begin
      case (cmd.src)
        SRC_AB:   begin mul_a = {1'b0, opa};       mul_b = {1'b0, opb};       end
        SRC_AR2:  begin mul_a = {1'b0, opa};       mul_b = {1'b0, r_squared}; end
        SRC_A1:   begin mul_a = {1'b0, opa};       mul_b = R_BITS'(1);        end
        SRC_R21:  begin mul_a = {1'b0, r_squared}; mul_b = R_BITS'(1);        end
        SRC_ACCB: begin mul_a = {1'b0, acc};       mul_b = {1'b0, base};      end
        default:  begin mul_a = {1'b0, base};      mul_b = {1'b0, base};      end
      endcase
    end else if (cmd.phase == 2'd2) begin
      mul_b = {1'b0, modulus};
    end
  end

  assign mul_p = mul_a * mul_b;

  // final reduction step
  assign t_raw = R_BITS'(xhi) + R_BITS'(modulus) - mprod[2*R_BITS-1:R_BITS];
  assign t_red = (t_raw >= R_BITS'(modulus)) ? t_raw - R_BITS'(modulus) : t_raw;

  // add and subtract
  assign sum_ab = {1'b0, opa} + {1'b0, opb};
  assign dif_ab = {1'b0, opa} + {1'b0, modulus} - {1'b0, opb};
  always_comb begin
    if (kind == REQ_ADD)
      addsub = (sum_ab >= {1'b0, modulus}) ? VAL_W'(sum_ab - {1'b0, modulus})
                                           : sum_ab[VAL_W-1:0];
    else
      addsub = (opa >= opb) ? opa - opb : dif_ab[VAL_W-1:0];
  end

  // operand, exponent and product registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= req_type;
      bad  <= bad_in;
      opa  <= operand_a;
      opb  <= operand_b;
      base <= operand_a;
      e    <= (req_type == REQ_INV) ? EXP_W'(modulus - VAL_W'(2)) : exponent;
    end
    if (cmd.e_shift) e <= e >> 1;
    if (cmd.mont_en) begin
      case (cmd.phase)
        2'd0: mprod <= mul_p;
        2'd1: begin
          xhi   <= mprod[61:32];
          mprod <= {R_BITS'(0), mul_p[R_BITS-1:0]};
        end
        2'd2: mprod <= mul_p;
        default: begin
          case (cmd.dst)
            DST_ACC:  acc  <= t_red[VAL_W-1:0];
            DST_BASE: base <= t_red[VAL_W-1:0];
            default:  result <= t_red[VAL_W-1:0];
          endcase
        end
      endcase
    end
    if (cmd.fin_addsub) result <= addsub;
    if (cmd.fin_acc)    result <= acc;
    if (cmd.fin_bad)    result <= '0;
  end

  // error flag
  always_ff @(posedge clk) begin
    if (rst) begin
      error <= 1'b0;
    end else if (cmd.load) begin
      error <= 1'b0;
    end else if (cmd.fin_bad) begin
      error <= 1'b1;
    end
  end

  assign stat.bad       = bad;
  assign stat.kind      = kind;
  assign stat.e_zero    = (e == '0);
  assign stat.e_lsb     = e[0];
  assign stat.e_hi_zero = (e[EXP_W-1:1] == '0);

endmodule

// ----- rtl/mma_control.sv -----
// controller of the montgomery modular alu: sequences products, the power
// loop and the result strobe; uses mma_pkg
`timescale 1ns / 1ps

module mma_control (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  input  mma_pkg::stat_t stat,
  output mma_pkg::cmd_t  cmd
);
  import mma_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_M0   = 4'd2;
  localparam logic [3:0] S_M1   = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;
  localparam logic [3:0] S_PCHK = 4'd6;
  localparam logic [3:0] S_PSQ  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state, state_next;
  logic [3:0] ret, ret_next;
  logic [2:0] src, src_next;
  logic [1:0] dst, dst_next;

  // state and product setup registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      src   <= SRC_AB;
      dst   <= DST_RES;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      src   <= src_next;
      dst   <= dst_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ret_next   = ret;
    src_next   = src;
    dst_next   = dst;
    cmd        = '0;
    cmd.src    = src;
    cmd.dst    = dst;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_M0;
        dst_next   = DST_RES;
        ret_next   = S_DONE;
        if (stat.bad) begin
          cmd.fin_bad = 1'b1;
          state_next  = S_DONE;
        end else begin
          case (stat.kind)
            REQ_ADD, REQ_SUB: begin
              cmd.fin_addsub = 1'b1;
              state_next     = S_DONE;
            end
            REQ_MUL:  src_next = SRC_AB;
            REQ_TO:   src_next = SRC_AR2;
            REQ_FROM: src_next = SRC_A1;
            default: begin
              src_next = SRC_R21;
              dst_next = DST_ACC;
              ret_next = S_PCHK;
            end
          endcase
        end
      end
      S_M0: begin
        cmd.mont_en = 1'b1;
        cmd.phase   = 2'd0;
        state_next  = S_M1;
      end
      S_M1: begin
        cmd.mont_en = 1'b1;
        cmd.phase   = 2'd1;
        state_next  = S_M2;
      end
      S_M2: begin
        cmd.mont_en = 1'b1;
        cmd.phase   = 2'd2;
        state_next  = S_M3;
      end
      S_M3: begin
        cmd.mont_en = 1'b1;
        cmd.phase   = 2'd3;
        state_next  = ret;
      end
      S_PCHK: begin
        if (stat.e_zero) begin
          cmd.fin_acc = 1'b1;
          state_next  = S_DONE;
        end else if (stat.e_lsb) begin
          src_next   = SRC_ACCB;
          dst_next   = DST_ACC;
          ret_next   = S_PSQ;
          state_next = S_M0;
        end else begin
          state_next = S_PSQ;
        end
      end
      S_PSQ: begin
        cmd.e_shift = 1'b1;
        if (stat.e_hi_zero) begin
          cmd.fin_acc = 1'b1;
          state_next  = S_DONE;
        end else begin
          src_next   = SRC_BB;
          dst_next   = DST_BASE;
          ret_next   = S_PCHK;
          state_next = S_M0;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule
